[rtl/altbl_pkg.sv]
// Shared widths, operation and status codes, and control types of the list engine.
`default_nettype none

package altbl_pkg;

  localparam int FUNC_W = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 7;
  localparam int LEN_W  = 7;

  localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  localparam logic [POS_W-1:0] POS_NONE = 7'h7F;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_APPEND,
    DP_RES_FULL,
    DP_RES_MISS,
    DP_RES_NOP,
    DP_READ_PTR,
    DP_READ_PREV,
    DP_NEXT,
    DP_FOUND,
    DP_REM_START,
    DP_REM_SHIFT,
    DP_COUNT_DEC,
    DP_INS_START,
    DP_INS_SHIFT,
    DP_PLACE
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              hit;
    logic              ptr_lt_count;
    logic              ptr_eq_idx;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/altbl_if.sv]
// Request and result channel interfaces of the list engine.
`default_nettype none

interface altbl_req_if import altbl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;
  logic signed [WORD_W-1:0] anchor;

  modport source (output valid, output func, output value, output anchor, input ready);
  modport sink   (input valid, input func, input value, input anchor, output ready);
endinterface

interface altbl_rsp_if import altbl_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [POS_W-1:0] position;
  logic [LEN_W-1:0]        length;

  modport source (output valid, output status, output position, output length, input ready);
  modport sink   (input valid, input status, input position, input length, output ready);
endinterface

`default_nettype wire

[rtl/array_list_table_engine.sv]
// Ordered list of signed words in a one-read, one-write memory with append, insert, remove and find.
// Each request transfer gives one result transfer with a status, the position concerned
// (-1 as all ones when none) and the list length afterwards. One request is handled at a
// time: after the request transfer the engine decodes it, then reads and compares each
// entry the search visits and reads and writes each entry an insert or remove moves, with
// a closing step on a search miss, a completed insert or a remove. Search and shift
// together touch at most CAPACITY entries. The result then waits for its own transfer,
// and the engine returns to idle before the next request is taken. The element memory
// gives one registered read and one write per cycle, so each compared or moved entry
// takes a read step and then a compare or write step. No clearing pass follows reset;
// the list is empty and a request can be taken as soon as reset is released.
`default_nettype none

module array_list_table_engine import altbl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  altbl_req_if.sink   in_req,
  altbl_rsp_if.source out_rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each request
  altbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store the list and form the result
  altbl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .func_in   (in_req.func),
    .value_in  (in_req.value),
    .anchor_in (in_req.anchor),
    .stat      (stat),
    .status    (out_rsp.status),
    .position  (out_rsp.position),
    .length    (out_rsp.length)
  );

endmodule

`default_nettype wire

[rtl/altbl_dp.sv]
// Datapath of the list engine: element memory, count, walk pointer and result registers.
`default_nettype none

module altbl_dp import altbl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  input  wire logic [FUNC_W-1:0]        func_in,
  input  wire logic signed [WORD_W-1:0] value_in,
  input  wire logic signed [WORD_W-1:0] anchor_in,
  output dp_stat_t                      stat,
  output logic [STAT_W-1:0]             status,
  output logic signed [POS_W-1:0]       position,
  output logic [LEN_W-1:0]              length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [FUNC_W-1:0] func_r;
  logic [WORD_W-1:0] value_r;
  logic [WORD_W-1:0] anchor_r;
  logic [WORD_W-1:0] rdata_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              none_r, none_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [CW-1:0]     ptr_m1;
  logic [WORD_W-1:0] key;
  logic              is_insert;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  assign ptr_m1    = ptr_r - 1'b1;
  assign is_insert = (func_r == FN_INS_AFTER) || (func_r == FN_INS_BEFORE);
  assign key       = is_insert ? anchor_r : value_r;

  // Report to the controller
  always_comb begin
    stat.func         = func_r;
    stat.full         = (count_r == CW'(CAPACITY));
    stat.hit          = (rdata_r == key);
    stat.ptr_lt_count = (ptr_r < count_r);
    stat.ptr_eq_idx   = (ptr_r == idx_r);
  end

  // Decode memory port use
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = rdata_r;
    re    = 1'b0;
    raddr = ptr_r[AW-1:0];
    case (cmd)
      DP_APPEND: begin
        we    = 1'b1;
        waddr = count_r[AW-1:0];
        wdata = value_r;
      end
      DP_REM_SHIFT: begin
        we    = 1'b1;
        waddr = ptr_m1[AW-1:0];
      end
      DP_INS_SHIFT: begin
        we = 1'b1;
      end
      DP_PLACE: begin
        we    = 1'b1;
        wdata = value_r;
      end
      DP_READ_PTR: begin
        re = 1'b1;
      end
      DP_READ_PREV: begin
        re    = 1'b1;
        raddr = ptr_m1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Write and read the element memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Advance count, pointer and result fields
  always_comb begin
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    none_nxt   = none_r;
    status_nxt = status_r;
    case (cmd)
      DP_LOAD: begin
        ptr_nxt = '0;
      end
      DP_APPEND: begin
        idx_nxt    = count_r;
        none_nxt   = 1'b0;
        status_nxt = STAT_OK;
        count_nxt  = count_r + 1'b1;
      end
      DP_RES_FULL: begin
        none_nxt   = 1'b1;
        status_nxt = STAT_FULL;
      end
      DP_RES_MISS: begin
        none_nxt   = 1'b1;
        status_nxt = STAT_NOT_FOUND;
      end
      DP_RES_NOP: begin
        none_nxt   = 1'b1;
        status_nxt = STAT_OK;
      end
      DP_NEXT: begin
        ptr_nxt = ptr_r + 1'b1;
      end
      DP_FOUND: begin
        idx_nxt    = ptr_r;
        none_nxt   = 1'b0;
        status_nxt = STAT_OK;
      end
      DP_REM_START: begin
        idx_nxt    = ptr_r;
        none_nxt   = 1'b0;
        status_nxt = STAT_OK;
        ptr_nxt    = ptr_r + 1'b1;
      end
      DP_REM_SHIFT: begin
        ptr_nxt = ptr_r + 1'b1;
      end
      DP_COUNT_DEC: begin
        count_nxt = count_r - 1'b1;
      end
      DP_INS_START: begin
        idx_nxt    = ptr_r + CW'(func_r == FN_INS_AFTER);
        none_nxt   = 1'b0;
        status_nxt = STAT_OK;
        ptr_nxt    = count_r;
      end
      DP_INS_SHIFT: begin
        ptr_nxt = ptr_m1;
      end
      DP_PLACE: begin
        count_nxt = count_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold the element count under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold the item fields, pointer and result fields
  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD) begin
      func_r   <= func_in;
      value_r  <= value_in;
      anchor_r <= anchor_in;
    end
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    none_r   <= none_nxt;
    status_r <= status_nxt;
  end

  assign status   = status_r;
  assign position = none_r ? POS_NONE : POS_W'(idx_r);
  assign length   = LEN_W'(count_r);

endmodule

`default_nettype wire

[rtl/altbl_ctrl.sv]
// Controller state machine of the list engine: search, shift and result sequencing.
`default_nettype none

module altbl_ctrl import altbl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_REM_RD,
    S_REM_WR,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;

  // Pick next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd       = DP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FN_APPEND: begin
            cmd       = stat.full ? DP_RES_FULL : DP_APPEND;
            state_nxt = S_DONE;
          end
          FN_INS_AFTER, FN_INS_BEFORE, FN_REMOVE, FN_FIND: begin
            state_nxt = S_SRCH_RD;
          end
          default: begin
            cmd       = DP_RES_NOP;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (stat.ptr_lt_count) begin
          cmd       = DP_READ_PTR;
          state_nxt = S_SRCH_CMP;
        end else begin
          cmd       = DP_RES_MISS;
          state_nxt = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (!stat.hit) begin
          cmd       = DP_NEXT;
          state_nxt = S_SRCH_RD;
        end else if (stat.func == FN_FIND) begin
          cmd       = DP_FOUND;
          state_nxt = S_DONE;
        end else if (stat.func == FN_REMOVE) begin
          cmd       = DP_REM_START;
          state_nxt = S_REM_RD;
        end else if (stat.full) begin
          cmd       = DP_RES_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd       = DP_INS_START;
          state_nxt = S_INS_RD;
        end
      end
      S_REM_RD: begin
        if (stat.ptr_lt_count) begin
          cmd       = DP_READ_PTR;
          state_nxt = S_REM_WR;
        end else begin
          cmd       = DP_COUNT_DEC;
          state_nxt = S_DONE;
        end
      end
      S_REM_WR: begin
        cmd       = DP_REM_SHIFT;
        state_nxt = S_REM_RD;
      end
      S_INS_RD: begin
        if (stat.ptr_eq_idx) begin
          cmd       = DP_PLACE;
          state_nxt = S_DONE;
        end else begin
          cmd       = DP_READ_PREV;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd       = DP_INS_SHIFT;
        state_nxt = S_INS_RD;
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= (state_nxt == S_DONE);
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
